### design/sbf_pkg.sv
// Shared types, constants and helper functions for the sentence boundary finder
`default_nettype none

package sbf_pkg;

  // field widths
  localparam int CLASS_W = 4;
  localparam int BYTES_W = 3;
  localparam int OUT_W   = 16;

  // sentence length counter width (saturating)
  localparam int LEN_W   = 16;

  // result queue sizing
  localparam int MAX_RES   = 2;
  localparam int RES_IDX_W = $clog2(MAX_RES);
  localparam int Q_DEPTH   = 4;
  localparam int Q_IDX_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  // input is taken only while the queue can absorb a full burst of results
  localparam logic [Q_CNT_W-1:0] Q_ROOM = Q_CNT_W'(Q_DEPTH - MAX_RES);

  // sentence-break classes
  typedef enum logic [CLASS_W-1:0] {
    CLS_OTHER   = 4'd0,
    CLS_CR      = 4'd1,
    CLS_LF      = 4'd2,
    CLS_SEP     = 4'd3,
    CLS_SP      = 4'd4,
    CLS_LOWER   = 4'd5,
    CLS_UPPER   = 4'd6,
    CLS_OLETTER = 4'd7,
    CLS_NUMERIC = 4'd8,
    CLS_ATERM   = 4'd9,
    CLS_STERM   = 4'd10,
    CLS_CLOSE   = 4'd11,
    CLS_SCONT   = 4'd12
  } class_t;

  // matcher phases
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_AFTER_CR    = 3'd1,
    PH_AFTER_ATERM = 3'd2,
    PH_CLOSE_RUN   = 3'd3,
    PH_SP_RUN      = 3'd4,
    PH_NONLETTER   = 3'd5
  } phase_t;

  // open sentence: byte count, sticky saturation, open flag
  typedef struct packed {
    logic [LEN_W-1:0] cnt;
    logic             sat;
    logic             open;
  } sent_t;

  // saturating add result
  typedef struct packed {
    logic [LEN_W-1:0] val;
    logic             ovf;
  } sadd_t;

  // one result transaction
  typedef struct packed {
    logic [OUT_W-1:0] sentence_bytes;
    logic             length_saturated;
    logic             text_done;
    logic             last_of_run;
  } res_t;

  // undefined class codes count as other
  function automatic class_t map_class(logic [CLASS_W-1:0] raw);
    class_t c;
    if (raw > CLS_SCONT) begin
      c = CLS_OTHER;
    end else begin
      c = class_t'(raw);
    end
    return c;
  endfunction

  function automatic logic is_sep(class_t c);
    return (c == CLS_CR) || (c == CLS_LF) || (c == CLS_SEP);
  endfunction

  function automatic logic is_term(class_t c);
    return (c == CLS_ATERM) || (c == CLS_STERM);
  endfunction

  function automatic logic is_letter(class_t c);
    return (c == CLS_LOWER) || (c == CLS_UPPER) || (c == CLS_OLETTER);
  endfunction

  function automatic logic is_nonletter(class_t c);
    return !is_letter(c) && !is_sep(c) && !is_term(c);
  endfunction

  // add clamped at all ones, overflow reported
  function automatic sadd_t sat_add(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    sadd_t r;
    s = {1'b0, a} + {1'b0, b};
    if (s[LEN_W]) begin
      r.val = '1;
      r.ovf = 1'b1;
    end else begin
      r.val = s[LEN_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // byte length widened to the counter
  function automatic logic [LEN_W-1:0] ext_bytes(logic [BYTES_W-1:0] b);
    return LEN_W'(b);
  endfunction

  // counter value to the output field width
  function automatic logic [OUT_W-1:0] to_out(logic [LEN_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### design/sbf_if.sv
// Valid/ready channel interfaces for character input and sentence results
`default_nettype none

interface sbf_in_if;
  logic                        valid;
  logic                        ready;
  logic [sbf_pkg::CLASS_W-1:0] char_class;
  logic [sbf_pkg::BYTES_W-1:0] char_bytes;
  logic                        end_of_text;

  modport source (output valid, char_class, char_bytes, end_of_text, input ready);
  modport sink   (input valid, char_class, char_bytes, end_of_text, output ready);
endinterface

interface sbf_out_if;
  logic                      valid;
  logic                      ready;
  logic [sbf_pkg::OUT_W-1:0] sentence_bytes;
  logic                      length_saturated;
  logic                      text_done;
  logic                      last_of_run;

  modport source (output valid, sentence_bytes, length_saturated, text_done, last_of_run,
                  input ready);
  modport sink   (input valid, sentence_bytes, length_saturated, text_done, last_of_run,
                  output ready);
endinterface

`default_nettype wire

### design/sentence_boundary_finder.sv
// Sentence boundary finder top level: rule matcher and result queue
//
// Takes one character per cycle (sentence-break class, byte length, end-of-text
// mark) and reports the byte length of every sentence as soon as it is known to
// be complete, saturating at the counter width. A character is processed in the
// cycle it is accepted; its results (zero, one or two) enter a four-entry result
// queue and appear on the output from the next cycle on. The input accepts a
// transaction in every cycle while the queue holds at most two results, so with
// a consumer that keeps up the block sustains one character per cycle; two
// results from one character leave the queue one after the other. After end of text the
// whole matcher state returns to its reset value.
`default_nettype none

module sentence_boundary_finder (
  input  wire            clk,
  input  wire            rst_n,
  sbf_in_if.sink         in_chan,
  sbf_out_if.source      out_chan
);

  // matcher state
  sbf_pkg::phase_t                phase_r, phase_nxt;
  sbf_pkg::class_t                lb0_r, lb0_nxt;
  sbf_pkg::class_t                lb1_r, lb1_nxt;
  sbf_pkg::sent_t                 sent_r, sent_nxt;
  logic [sbf_pkg::LEN_W-1:0]      run_r, run_nxt;
  logic                           run_sat_r, run_sat_nxt;
  logic                           aterm_r, aterm_nxt;

  // result queue
  sbf_pkg::res_t                  q_r [sbf_pkg::Q_DEPTH];
  logic [sbf_pkg::Q_IDX_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [sbf_pkg::Q_IDX_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [sbf_pkg::Q_CNT_W-1:0]    q_cnt_r, q_cnt_nxt;

  // per-transaction results
  sbf_pkg::res_t                  res [sbf_pkg::MAX_RES];
  logic [sbf_pkg::Q_CNT_W-1:0]    nres;

  logic in_ready;
  logic accept;
  logic pop;
  logic [sbf_pkg::Q_IDX_W-1:0]    wr_ptr_p1;

  // handshake
  assign in_ready       = (q_cnt_r <= sbf_pkg::Q_ROOM);
  assign in_chan.ready  = in_ready;
  assign accept         = in_chan.valid && in_ready;
  assign out_chan.valid = (q_cnt_r != '0);
  assign pop            = out_chan.valid && out_chan.ready;

  // queue head drives the result channel
  assign out_chan.sentence_bytes   = q_r[rd_ptr_r].sentence_bytes;
  assign out_chan.length_saturated = q_r[rd_ptr_r].length_saturated;
  assign out_chan.text_done        = q_r[rd_ptr_r].text_done;
  assign out_chan.last_of_run      = q_r[rd_ptr_r].last_of_run;

  // rule matcher: next state and results for the offered character
  always_comb begin
    sbf_pkg::class_t           c;
    logic [sbf_pkg::LEN_W-1:0] b;
    logic                      pre_close, load_run, merge_run, add_s, post_close;
    logic                      run_add, run_fresh, run_clear;
    logic                      close_run_path, space_path, idle_path;
    logic                      eot;
    sbf_pkg::sent_t            s;
    sbf_pkg::sadd_t            t;
    logic                      emit [4];
    sbf_pkg::sent_t            ev [4];

    c   = sbf_pkg::map_class(in_chan.char_class);
    b   = sbf_pkg::ext_bytes(in_chan.char_bytes);
    eot = in_chan.end_of_text;
    t   = '0;

    pre_close      = 1'b0;
    load_run       = 1'b0;
    merge_run      = 1'b0;
    add_s          = 1'b0;
    post_close     = 1'b0;
    run_add        = 1'b0;
    run_fresh      = 1'b0;
    run_clear      = 1'b0;
    close_run_path = 1'b0;
    space_path     = 1'b0;
    idle_path      = 1'b0;
    phase_nxt      = phase_r;
    aterm_nxt      = aterm_r;

    // phase dispatch
    unique case (phase_r)
      sbf_pkg::PH_AFTER_CR: begin
        if (c == sbf_pkg::CLS_LF) begin
          add_s      = 1'b1;
          post_close = 1'b1;
          phase_nxt  = sbf_pkg::PH_IDLE;
        end else begin
          pre_close = 1'b1;
          idle_path = 1'b1;
        end
      end
      sbf_pkg::PH_AFTER_ATERM: begin
        if ((c == sbf_pkg::CLS_NUMERIC) ||
            ((c == sbf_pkg::CLS_UPPER) && (lb1_r == sbf_pkg::CLS_UPPER))) begin
          idle_path = 1'b1;
        end else begin
          phase_nxt      = sbf_pkg::PH_CLOSE_RUN;
          close_run_path = 1'b1;
        end
      end
      sbf_pkg::PH_CLOSE_RUN: begin
        close_run_path = 1'b1;
      end
      sbf_pkg::PH_SP_RUN: begin
        if (c == sbf_pkg::CLS_SP) begin
          add_s = 1'b1;
        end else begin
          space_path = 1'b1;
        end
      end
      sbf_pkg::PH_NONLETTER: begin
        if (sbf_pkg::is_nonletter(c)) begin
          run_add = 1'b1;
        end else if (c == sbf_pkg::CLS_LOWER) begin
          merge_run = 1'b1;
          run_clear = 1'b1;
          idle_path = 1'b1;
        end else begin
          pre_close = 1'b1;
          load_run  = 1'b1;
          run_clear = 1'b1;
          idle_path = 1'b1;
        end
      end
      default: begin
        idle_path = 1'b1;
      end
    endcase

    // close and space run after a terminator
    if (close_run_path) begin
      if (c == sbf_pkg::CLS_CLOSE) begin
        add_s = 1'b1;
      end else if (c == sbf_pkg::CLS_SP) begin
        add_s     = 1'b1;
        phase_nxt = sbf_pkg::PH_SP_RUN;
      end else begin
        space_path = 1'b1;
      end
    end

    // first character after the close/space run
    if (space_path) begin
      priority if (sbf_pkg::is_sep(c) || sbf_pkg::is_term(c) ||
                   (c == sbf_pkg::CLS_SCONT)) begin
        idle_path = 1'b1;
      end else if (aterm_r && (c == sbf_pkg::CLS_LOWER)) begin
        idle_path = 1'b1;
      end else if (aterm_r && sbf_pkg::is_nonletter(c)) begin
        phase_nxt = sbf_pkg::PH_NONLETTER;
        run_fresh = 1'b1;
      end else begin
        pre_close = 1'b1;
        idle_path = 1'b1;
      end
    end

    // plain character handling
    if (idle_path) begin
      add_s     = 1'b1;
      phase_nxt = sbf_pkg::PH_IDLE;
      unique case (c)
        sbf_pkg::CLS_CR:    phase_nxt = sbf_pkg::PH_AFTER_CR;
        sbf_pkg::CLS_LF,
        sbf_pkg::CLS_SEP:   post_close = 1'b1;
        sbf_pkg::CLS_ATERM: begin
          phase_nxt = sbf_pkg::PH_AFTER_ATERM;
          aterm_nxt = 1'b1;
        end
        sbf_pkg::CLS_STERM: begin
          phase_nxt = sbf_pkg::PH_CLOSE_RUN;
          aterm_nxt = 1'b0;
        end
        default:            phase_nxt = sbf_pkg::PH_IDLE;
      endcase
    end

    // non-letter run after an aterm
    run_nxt     = run_r;
    run_sat_nxt = run_sat_r;
    if (run_add) begin
      t           = sbf_pkg::sat_add(run_r, b);
      run_nxt     = t.val;
      run_sat_nxt = run_sat_r | t.ovf;
    end else if (run_fresh) begin
      run_nxt     = b;
      run_sat_nxt = 1'b0;
    end else if (run_clear) begin
      run_nxt     = '0;
      run_sat_nxt = 1'b0;
    end

    // sentence update, with close points in order
    s       = sent_r;
    emit[0] = pre_close && s.open;
    ev[0]   = s;
    if (pre_close) begin
      if (load_run) begin
        s.cnt  = run_r;
        s.sat  = run_sat_r;
        s.open = 1'b1;
      end else begin
        s = '0;
      end
    end
    if (merge_run) begin
      t     = sbf_pkg::sat_add(s.cnt, run_r);
      s.cnt = t.val;
      s.sat = s.sat | t.ovf | run_sat_r;
    end
    if (add_s) begin
      t      = sbf_pkg::sat_add(s.cnt, b);
      s.cnt  = t.val;
      s.sat  = s.sat | t.ovf;
      s.open = 1'b1;
    end
    emit[1] = post_close && s.open;
    ev[1]   = s;
    if (post_close) begin
      s = '0;
    end

    // end of text flushes a pending run and the open sentence
    emit[2] = eot && (phase_nxt == sbf_pkg::PH_NONLETTER) && s.open;
    ev[2]   = s;
    if (eot && (phase_nxt == sbf_pkg::PH_NONLETTER)) begin
      s.cnt  = run_nxt;
      s.sat  = run_sat_nxt;
      s.open = 1'b1;
    end
    emit[3] = eot && s.open;
    ev[3]   = s;
    sent_nxt = eot ? '0 : s;

    lb1_nxt = lb0_r;
    lb0_nxt = c;
    if (eot) begin
      phase_nxt   = sbf_pkg::PH_IDLE;
      lb0_nxt     = sbf_pkg::CLS_OTHER;
      lb1_nxt     = sbf_pkg::CLS_OTHER;
      run_nxt     = '0;
      run_sat_nxt = 1'b0;
      aterm_nxt   = 1'b0;
    end

    // gather up to two results in order
    nres = '0;
    for (int i = 0; i < sbf_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (emit[i] && (nres < sbf_pkg::Q_CNT_W'(sbf_pkg::MAX_RES))) begin
        res[nres[sbf_pkg::RES_IDX_W-1:0]].sentence_bytes   = sbf_pkg::to_out(ev[i].cnt);
        res[nres[sbf_pkg::RES_IDX_W-1:0]].length_saturated = ev[i].sat;
        nres = nres + 1'b1;
      end
    end
    if (nres != '0) begin
      res[nres[sbf_pkg::RES_IDX_W-1:0] - 1'b1].last_of_run = 1'b1;
      res[nres[sbf_pkg::RES_IDX_W-1:0] - 1'b1].text_done   = eot;
    end
  end

  // queue pointer and fill count
  assign wr_ptr_p1 = wr_ptr_r + {{(sbf_pkg::Q_IDX_W-1){1'b0}}, 1'b1};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    q_cnt_nxt  = q_cnt_r - {{(sbf_pkg::Q_CNT_W-1){1'b0}}, pop};
    rd_ptr_nxt = rd_ptr_r + {{(sbf_pkg::Q_IDX_W-1){1'b0}}, pop};
    if (accept) begin
      wr_ptr_nxt = wr_ptr_r + nres[sbf_pkg::Q_IDX_W-1:0];
      q_cnt_nxt  = q_cnt_r + nres - {{(sbf_pkg::Q_CNT_W-1){1'b0}}, pop};
    end
  end

  // control and matcher registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sbf_pkg::PH_IDLE;
      lb0_r     <= sbf_pkg::CLS_OTHER;
      lb1_r     <= sbf_pkg::CLS_OTHER;
      sent_r    <= '0;
      run_r     <= '0;
      run_sat_r <= 1'b0;
      aterm_r   <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_cnt_r   <= '0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        lb0_r     <= lb0_nxt;
        lb1_r     <= lb1_nxt;
        sent_r    <= sent_nxt;
        run_r     <= run_nxt;
        run_sat_r <= run_sat_nxt;
        aterm_r   <= aterm_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      if (nres != '0) begin
        q_r[wr_ptr_r] <= res[0];
      end
      if (nres > {{(sbf_pkg::Q_CNT_W-1){1'b0}}, 1'b1}) begin
        q_r[wr_ptr_p1] <= res[1];
      end
    end
  end

endmodule

`default_nettype wire
